@@ design/afl_pkg.sv @@
// Package for the active fault list: sizes, opcodes, FSM encoding and the
// command/status structs between controller and datapath. No dependencies.
`default_nettype none
package afl_pkg;

  localparam int DEPTH     = 16;
  localparam int CODE_BITS = 16;
  localparam int IN_CODE_W = 16;
  localparam int OP_W      = 2;
  localparam int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W     = $clog2(DEPTH + 1);

  localparam logic [OP_W-1:0] OP_SET   = 2'd0;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

  typedef logic [CODE_BITS-1:0] code_t;
  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [IDX_W-1:0]     idx_t;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SEARCH = 4'b0010,
    ST_SHIFT  = 4'b0100,
    ST_FINISH = 4'b1000
  } state_t;

  typedef struct packed {
    logic load;
    logic search;
    logic shift;
    logic finish;
  } afl_cmd_t;

  typedef struct packed {
    logic match;
    logic miss;
    logic shift_done;
    logic is_clear;
  } afl_status_t;

endpackage
`default_nettype wire

@@ design/afl_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module afl_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic                                  re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

@@ design/afl_datapath.sv @@
// Datapath of the active fault list: entry RAM, scan pointer, count,
// sticky overflow and result registers. Uses afl_pkg and afl_ram.
`default_nettype none
module afl_datapath
  import afl_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire afl_cmd_t            cmd,
  input  wire logic [OP_W-1:0]     in_opcode,
  input  wire logic [IN_CODE_W-1:0] in_fault_code,
  output afl_status_t              status,
  output logic                     out_valid,
  output logic                     out_found,
  output logic [CNT_W-1:0]         out_entry_count,
  output logic                     out_overflow
);

  logic [OP_W-1:0] op_r;
  code_t           code_r;
  cnt_t            cnt_r, cnt_nxt;
  logic            ovf_r, ovf_nxt;
  logic            hit_r;
  cnt_t            ptr_r;
  logic            pend_r;
  idx_t            pend_idx_r;
  logic            valid_r, found_r, ovf_out_r;
  cnt_t            cnt_out_r;

  logic   rd_en, wr_en;
  idx_t   wr_addr;
  code_t  wr_data, rd_data;
  logic   more, match, is_set, room;

  assign more   = ptr_r < cnt_r;
  assign match  = pend_r && (rd_data == code_r);
  assign is_set = op_r == OP_SET;
  assign room   = cnt_r < CNT_W'(DEPTH);

  assign status.match      = match;
  assign status.miss       = !pend_r && !more;
  assign status.shift_done = !pend_r && !more;
  assign status.is_clear   = op_r == OP_CLEAR;

  // read issue: search and shift both walk ptr_r, unless a hit ends the search
  assign rd_en = more && (cmd.shift || (cmd.search && !match));

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = pend_idx_r;
    wr_data = rd_data;
    if (cmd.shift && pend_r) begin
      wr_en   = 1'b1;
      wr_addr = IDX_W'(pend_idx_r - 1'b1);
    end else if (cmd.finish && is_set && room) begin
      wr_en   = 1'b1;
      wr_addr = cnt_r[IDX_W-1:0];
      wr_data = code_r;
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    ovf_nxt = ovf_r;
    if (is_set) begin
      if (room) begin
        cnt_nxt = cnt_r + 1'b1;
      end else begin
        ovf_nxt = 1'b1;
      end
    end else if (status.is_clear && hit_r) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  afl_ram #(
    .WIDTH (CODE_BITS),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (rd_en),
    .raddr (ptr_r[IDX_W-1:0]),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      ovf_r     <= 1'b0;
      pend_r    <= 1'b0;
      valid_r   <= 1'b0;
      cnt_out_r <= '0;
      ovf_out_r <= 1'b0;
      found_r   <= 1'b0;
    end else begin
      valid_r <= 1'b0;
      if (cmd.load) begin
        op_r   <= in_opcode;
        code_r <= in_fault_code[CODE_BITS-1:0];
        ptr_r  <= '0;
        pend_r <= 1'b0;
        hit_r  <= 1'b0;
      end else if (cmd.search && match) begin
        hit_r  <= 1'b1;
        ptr_r  <= CNT_W'({1'b0, pend_idx_r}) + 1'b1;
        pend_r <= 1'b0;
      end else if (cmd.search || cmd.shift) begin
        pend_r <= rd_en;
        if (rd_en) begin
          pend_idx_r <= ptr_r[IDX_W-1:0];
          ptr_r      <= ptr_r + 1'b1;
        end
      end
      if (cmd.finish) begin
        cnt_r     <= cnt_nxt;
        ovf_r     <= ovf_nxt;
        valid_r   <= 1'b1;
        found_r   <= hit_r;
        cnt_out_r <= cnt_nxt;
        ovf_out_r <= ovf_nxt;
      end
    end
  end

  assign out_valid       = valid_r;
  assign out_found       = found_r;
  assign out_entry_count = cnt_out_r;
  assign out_overflow    = ovf_out_r;

endmodule
`default_nettype wire

@@ design/afl_ctrl.sv @@
// Controller FSM of the active fault list: sequences search, shift and
// finish over the datapath. Uses afl_pkg.
`default_nettype none
module afl_ctrl
  import afl_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire afl_status_t status,
  output afl_cmd_t         cmd,
  output logic             busy
);

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (status.match) begin
          state_nxt = status.is_clear ? ST_SHIFT : ST_FINISH;
        end else if (status.miss) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_SHIFT: begin
        if (status.shift_done) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy       = state_r != ST_IDLE;
  assign cmd.load   = (state_r == ST_IDLE) && start;
  assign cmd.search = state_r == ST_SEARCH;
  assign cmd.shift  = state_r == ST_SHIFT;
  assign cmd.finish = state_r == ST_FINISH;

endmodule
`default_nettype wire

@@ design/active_fault_list_unit.sv @@
// Top level of the active fault list: controller and datapath joined.
// Uses afl_pkg, afl_ctrl and afl_datapath.
//
// Usage
//   Command channel: drive in_opcode and in_fault_code with start high; the
//   transfer happens at the rising edge where start is high and busy low.
//   Opcodes: set appends the code, clear removes its first copy and closes
//   the gap, query only looks. The unused opcode behaves as a query.
//   Result channel: out_valid is high for exactly one cycle per command,
//   carrying out_found (code present before the command), out_entry_count
//   (entries after it) and out_overflow (sticky, raised by a set on a full
//   list). The receiver cannot stall; the result is taken in that cycle.
//   Sequencing: the search walks the entry RAM one entry per cycle through its
//   single registered read port; a clear with a hit then shifts the later
//   entries down, one per cycle. A finish step follows and the result
//   appears in the cycle after it. Busy drops in the cycle the result is
//   shown, so a new command may be transferred then.
//   Reset: synchronous, active low; it empties the list and clears the
//   overflow flag. RAM contents are not cleared; only entries below the
//   count are ever read.
`default_nettype none
module active_fault_list_unit
  import afl_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [OP_W-1:0]      in_opcode,
  input  wire logic [IN_CODE_W-1:0] in_fault_code,
  output logic                      out_valid,
  output logic                      out_found,
  output logic [CNT_W-1:0]          out_entry_count,
  output logic                      out_overflow
);

  afl_cmd_t    cmd;
  afl_status_t status;

  // sequencing only; all state of the list lives in the datapath
  afl_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  afl_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_opcode       (in_opcode),
    .in_fault_code   (in_fault_code),
    .status          (status),
    .out_valid       (out_valid),
    .out_found       (out_found),
    .out_entry_count (out_entry_count),
    .out_overflow    (out_overflow)
  );

`ifndef SYNTH
  // an accepted command keeps the block busy in the next cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted command did not raise busy");

  // a result only follows a busy cycle (the finish step)
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result strobe without a command in flight");

  // the count never exceeds the list depth
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_entry_count <= CNT_W'(DEPTH)))
    else $error("entry count beyond depth");

  // overflow is sticky until reset
  assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $past(out_overflow)) |-> out_overflow)
    else $error("overflow flag dropped without reset");
`endif

endmodule
`default_nettype wire

@@ bench/tb_active_fault_list_unit.sv @@
// Self-checking testbench for active_fault_list_unit: directed and random
// set/clear/query commands, each result compared with a behavioural model.
// Depends on afl_pkg and the active_fault_list_unit RTL.
module tb_active_fault_list_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import afl_pkg::*;

  // The fourth opcode is not defined by the package; the block treats it
  // as a query.
  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

  localparam int unsigned SETTLE_CYCLES = 2 * DEPTH + 8;

  // Expected contents of one result transfer.
  typedef struct packed {
    logic found;
    cnt_t count;
    logic ovf;
  } fault_status_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic [OP_W-1:0]      in_opcode = OP_QUERY;
  logic [IN_CODE_W-1:0] in_fault_code = '0;
  logic                 busy;
  logic                 out_valid;
  logic                 out_found;
  logic [CNT_W-1:0]     out_entry_count;
  logic                 out_overflow;

  // Model state: the ordered fault list, its length and the sticky flag.
  code_t         fault_list [DEPTH];
  int unsigned   list_len = 0;
  logic          list_ovf = 1'b0;

  // Results still owed by the block, oldest first.
  fault_status_t expected_status [$];

  int unsigned   err_count = 0;
  bit            gaps_on = 1'b1;
  code_t         code_pool [8];

  active_fault_list_unit u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_opcode       (in_opcode),
    .in_fault_code   (in_fault_code),
    .out_valid       (out_valid),
    .out_found       (out_found),
    .out_entry_count (out_entry_count),
    .out_overflow    (out_overflow)
  );

  // 20 ns clock, low half first so no edge falls at time zero.
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  task automatic report_mismatch(input string msg);
    err_count++;
    $display("MISMATCH at %0t ns: %s", $time, msg);
  endtask

  // Applies one command to the model list and returns the status the block
  // should report for it. found is taken before the list is changed.
  function automatic fault_status_t apply_fault_op(input logic [OP_W-1:0] op,
                                                   input logic [IN_CODE_W-1:0] raw);
    code_t         code;
    int unsigned   pos;
    int unsigned   k;
    fault_status_t res;
    code = code_t'(raw);
    pos = list_len;
    for (k = 0; k < list_len; k++)
      if (pos == list_len && fault_list[k] == code) pos = k;
    res.found = (pos < list_len);
    case (op)
      OP_SET: begin
        // Append, duplicates allowed; a full list only raises the flag.
        if (list_len < DEPTH) begin
          fault_list[list_len] = code;
          list_len++;
        end else begin
          list_ovf = 1'b1;
        end
      end
      OP_CLEAR: begin
        // Drop the first copy and close the gap; a miss changes nothing.
        if (pos < list_len) begin
          for (k = pos; k + 1 < list_len; k++) fault_list[k] = fault_list[k + 1];
          list_len--;
        end
      end
      default: ; // query and the spare opcode only look
    endcase
    res.count = cnt_t'(list_len);
    res.ovf   = list_ovf;
    return res;
  endfunction

  // Sends one command. An idle gap of random length may come first, with
  // noise on the payload while start is low. start is left high after the
  // transfer so that back-to-back commands need no second assignment in
  // the same step; the gap loop of the next call lowers it when a gap is drawn.
  task automatic send_fault_cmd(input logic [OP_W-1:0] op,
                                input logic [IN_CODE_W-1:0] code);
    int unsigned gap;
    gap = gaps_on ? $urandom_range(0, 10) : 0;
    repeat (gap) begin
      start         <= 1'b0;
      in_opcode     <= OP_W'($urandom);
      in_fault_code <= IN_CODE_W'($urandom);
      @(posedge clk);
    end
    start         <= 1'b1;
    in_opcode     <= op;
    in_fault_code <= code;
    // busy read straight after the edge is its value before that edge,
    // so a low reading means the transfer happened at this edge.
    do @(posedge clk); while (busy !== 1'b0);
    expected_status.push_back(apply_fault_op(op, code));
  endtask

  // Result checker: every strobe is matched with the oldest expectation.
  always @(posedge clk) begin
    fault_status_t exp_status;
    if (rst_n === 1'b1 && out_valid !== 1'b0) begin
      if (out_valid !== 1'b1) begin
        report_mismatch("out_valid unknown");
      end else if (expected_status.size() == 0) begin
        report_mismatch("result transfer with no command outstanding");
      end else begin
        exp_status = expected_status.pop_front();
        if (out_found !== exp_status.found)
          report_mismatch($sformatf("found: got %b, expected %b",
                                    out_found, exp_status.found));
        if (out_entry_count !== exp_status.count)
          report_mismatch($sformatf("entry_count: got %0d, expected %0d",
                                    out_entry_count, exp_status.count));
        if (out_overflow !== exp_status.ovf)
          report_mismatch($sformatf("overflow: got %b, expected %b",
                                    out_overflow, exp_status.ovf));
      end
    end
  end

  // Commands on an empty list: nothing can be found, a clear has no match.
  task automatic test_empty_list();
    gaps_on = 1'b1;
    send_fault_cmd(OP_QUERY, 16'h0000);
    send_fault_cmd(OP_CLEAR, 16'hFFFF);
    send_fault_cmd(OP_SPARE, 16'h5A5A);
  endtask

  // Duplicates, clears of the first, middle and last entry, a clear that
  // misses on a non-empty list, and the spare opcode on a hit.
  task automatic test_basic_ops();
    gaps_on = 1'b1;
    send_fault_cmd(OP_SET,   16'hFFFF);
    send_fault_cmd(OP_SET,   16'h0000);
    send_fault_cmd(OP_SET,   16'hFFFF);
    send_fault_cmd(OP_SET,   16'h8001);
    send_fault_cmd(OP_QUERY, 16'hFFFF);
    send_fault_cmd(OP_SPARE, 16'h0000);
    send_fault_cmd(OP_CLEAR, 16'hFFFF); // first copy goes, second stays
    send_fault_cmd(OP_CLEAR, 16'hFFFF); // now in the middle
    send_fault_cmd(OP_CLEAR, 16'h8001); // last entry
    send_fault_cmd(OP_CLEAR, 16'h1234); // miss
  endtask

  // Random traffic. Codes come mostly from the list itself or from a small
  // pool so clears and queries hit often; the rest are fully random. The
  // set/clear balance is redrawn every 64 commands so the count wanders
  // between empty and full, and idle gaps are switched on and off with it.
  task automatic run_random_traffic(input int unsigned n_items, input bit allow_full);
    int unsigned          i;
    int unsigned          pick;
    int unsigned          set_pct;
    logic [OP_W-1:0]      op;
    logic [IN_CODE_W-1:0] code;
    set_pct = 40;
    for (i = 0; i < n_items; i++) begin
      if (i % 64 == 0) begin
        gaps_on = ($urandom_range(0, 3) != 0);
        set_pct = $urandom_range(25, 60);
      end
      pick = $urandom_range(0, 99);
      if (pick < set_pct) op = OP_SET;
      else if (pick < set_pct + 30) op = OP_CLEAR;
      else if (pick < set_pct + 35) op = OP_SPARE;
      else op = OP_QUERY;
      // Before the overflow test the list must never refuse a set.
      if (!allow_full && op == OP_SET && list_len == DEPTH) op = OP_CLEAR;
      pick = $urandom_range(0, 3);
      if (pick < 2 && list_len != 0)
        code = fault_list[$urandom_range(0, list_len - 1)];
      else if (pick < 3)
        code = code_pool[$urandom_range(0, 7)];
      else
        code = IN_CODE_W'($urandom);
      send_fault_cmd(op, code);
    end
  endtask

  task automatic test_random_below_full();
    run_random_traffic(1200, 1'b0);
  endtask

  // Fill the list, then set on a full list twice: the flag sticks and the
  // list is untouched. A clear frees a slot, the next set fits, and the
  // flag still reads high.
  task automatic test_overflow();
    gaps_on = 1'b1;
    while (list_len < DEPTH)
      send_fault_cmd(OP_SET, IN_CODE_W'($urandom));
    send_fault_cmd(OP_SET,   16'hFFFF);
    send_fault_cmd(OP_SET,   16'h0000);
    send_fault_cmd(OP_QUERY, 16'hFFFF);
    send_fault_cmd(OP_CLEAR, fault_list[DEPTH - 1]);
    send_fault_cmd(OP_SET,   16'hFFFF);
    send_fault_cmd(OP_QUERY, 16'hFFFF);
  endtask

  // Random traffic with the flag already set and sets on a full list allowed.
  task automatic test_random_past_full();
    run_random_traffic(650, 1'b1);
  endtask

  initial begin
    code_pool[0] = 16'h0000;
    code_pool[1] = 16'hFFFF;
    for (int p = 2; p < 8; p++) code_pool[p] = code_t'($urandom);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_list();
    test_basic_ops();
    test_random_below_full();
    test_overflow();
    test_random_past_full();

    // Last transfer just happened at this edge; drop start once.
    start <= 1'b0;
    while (expected_status.size() != 0) @(posedge clk);
    // Let any stray result show up before deciding.
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (err_count == 0) begin
      $display("tb_active_fault_list_unit: PASS");
    end else begin
      $display("tb_active_fault_list_unit: FAIL");
    end
    $finish;
  end

  // Watchdog: a correct run needs well under 2 ms; a hang ends the run here.
  initial begin
    #20_000_000;
    $display("tb_active_fault_list_unit: FAIL");
    $finish;
  end

endmodule

@@ filelist.f @@
design/afl_pkg.sv
design/afl_ram.sv
design/afl_datapath.sv
design/afl_ctrl.sv
design/active_fault_list_unit.sv
bench/tb_active_fault_list_unit.sv
